>>> src/ofl_pkg.sv
// Shared types and constants for the optical-flow light mode gate.
// Used by ofl_cfg_regs, ofl_mode_ctrl, ofl_gate and the top level.
// No dependencies.
package ofl_pkg;

    // Lighting mode codes
    localparam logic [1:0] MODE_BRIGHT   = 2'd0;
    localparam logic [1:0] MODE_LOW      = 2'd1;
    localparam logic [1:0] MODE_SUPERLOW = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINQ_BRIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINQ_LOW     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MINQ_SUPERLOW = 8'd3;

    // Register reset values
    localparam logic [3:0] DWELL_RESET        = 4'd10;
    localparam logic [7:0] MINQ_BRIGHT_RESET  = 8'd25;
    localparam logic [7:0] MINQ_LOW_RESET     = 8'd70;
    localparam logic [7:0] MINQ_SUPERLOW_RESET = 8'd85;

    // Shutter thresholds
    localparam logic [12:0] GATE_LIMIT_NORMAL   = 13'h1FF0;
    localparam logic [12:0] GATE_LIMIT_SUPERLOW = 13'h0BC0;
    localparam logic [12:0] SHUT_TO_BRIGHT      = 13'h0BB8;
    localparam logic [12:0] SHUT_TO_LOW         = 13'h03E8;
    localparam logic [12:0] SHUT_TO_DARKER      = 13'h1E1F;
    localparam logic [12:0] SHUT_FAST_LOW       = 13'h01F4;

    // Raw sum thresholds
    localparam logic [7:0] RSUM_BRIGHT_TO_LOW = 8'h3C;
    localparam logic [7:0] RSUM_LOW_TO_SUPER  = 8'h5A;

    // Dwell counter ceiling
    localparam logic [3:0] CNT_MAX = 4'd15;

    // Field widths
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 56;

    typedef struct packed {
        logic [3:0] dwell_count;
        logic [7:0] min_quality_bright;
        logic [7:0] min_quality_low;
        logic [7:0] min_quality_superlow;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cur_mode;
        logic [1:0] new_mode;
        logic       mode_changed;
    } mode_info_t;

endpackage

>>> src/optical_flow_light_mode_gate_unit.sv
// Top level of the optical-flow light mode gate.
// Depends on ofl_pkg, ofl_cfg_regs, ofl_gate and ofl_mode_ctrl.
//
// Usage:
//   s_* carries one motion burst per item as eight raw bytes. m_* returns
//   one result per burst: the assembled deltas (zeroed when gated), the
//   13-bit shutter value, the gate flag, the lighting mode after the burst
//   and a mode-change flag. cfg_* writes the dwell count and the three
//   quality bounds; it is always ready and is meant to be used while idle.
//   An accepted item waits in the input register; the gate and mode update
//   logic then loads the result register, which raises result valid.
//   Throughput is one item per cycle while m_tready is high; the mode and
//   dwell counters form a feedback loop, updated as each item enters the
//   result register. Reset puts the block in bright mode with cleared
//   counters and the register defaults, and empties both pipeline registers.
//   When m_tready is low the result is held; the input register still takes
//   one more item, after which s_tready drops until the result register
//   frees up.
module optical_flow_light_mode_gate_unit
    import ofl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // delta_x_low, delta_x_high, delta_y_low, delta_y_high,
    // surface_quality, raw_sum, shutter_high, shutter_low (8 bits each)
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // motion_x[15:0], motion_y[31:16], shutter_value[44:32], motion_gated[45],
    // new_mode[47:46], mode_changed[48], zero pad[55:49]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]            cfg_data
);

    logic                  in_valid_reg;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  advance;
    cfg_t                  cfg;
    mode_info_t            info;
    logic [12:0]           shutter_value;
    logic [15:0]           motion_x, motion_y;
    logic                  motion_gated;

    // Move the held item forward when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign shutter_value = {in_data_reg[52:48], in_data_reg[63:56]};

    ofl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ofl_mode_ctrl u_mode (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .dwell_count   (cfg.dwell_count),
        .shutter_value (shutter_value),
        .raw_sum       (in_data_reg[47:40]),
        .info          (info)
    );

    ofl_gate u_gate (
        .cfg             (cfg),
        .cur_mode        (info.cur_mode),
        .surface_quality (in_data_reg[39:32]),
        .shutter_value   (shutter_value),
        .delta_x         (in_data_reg[15:0]),
        .delta_y         (in_data_reg[31:16]),
        .motion_x        (motion_x),
        .motion_y        (motion_y),
        .motion_gated    (motion_gated)
    );

    // Input register: take a new item whenever it is empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    // Result register: load on advance, clear valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {7'd0, info.mode_changed, info.new_mode, motion_gated,
                             shutter_value, motion_y, motion_x};
        end
    end

endmodule

>>> src/ofl_cfg_regs.sv
// Configuration register file of the light mode gate.
// Depends on ofl_pkg for the register indexes and reset values.
module ofl_cfg_regs
    import ofl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the write; drop unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DWELL:         cfg_next.dwell_count          = cfg_data[3:0];
                CFG_MINQ_BRIGHT:   cfg_next.min_quality_bright   = cfg_data;
                CFG_MINQ_LOW:      cfg_next.min_quality_low      = cfg_data;
                CFG_MINQ_SUPERLOW: cfg_next.min_quality_superlow = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dwell_count          <= DWELL_RESET;
            cfg_reg.min_quality_bright   <= MINQ_BRIGHT_RESET;
            cfg_reg.min_quality_low      <= MINQ_LOW_RESET;
            cfg_reg.min_quality_superlow <= MINQ_SUPERLOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/ofl_gate.sv
// Motion gate: zero the deltas on poor quality with a long shutter.
// Depends on ofl_pkg for mode codes, limits and the cfg_t type.
module ofl_gate
    import ofl_pkg::*;
(
    input  cfg_t         cfg,
    input  logic [1:0]   cur_mode,
    input  logic [7:0]   surface_quality,
    input  logic [12:0]  shutter_value,
    input  logic [15:0]  delta_x,
    input  logic [15:0]  delta_y,
    output logic [15:0]  motion_x,
    output logic [15:0]  motion_y,
    output logic         motion_gated
);

    // Pick the mode's quality bound and shutter limit
    always_comb
    begin
        case (cur_mode)
            MODE_BRIGHT:
                motion_gated = (surface_quality < cfg.min_quality_bright) &&
                               (shutter_value >= GATE_LIMIT_NORMAL);
            MODE_LOW:
                motion_gated = (surface_quality < cfg.min_quality_low) &&
                               (shutter_value >= GATE_LIMIT_NORMAL);
            MODE_SUPERLOW:
                motion_gated = (surface_quality < cfg.min_quality_superlow) &&
                               (shutter_value >= GATE_LIMIT_SUPERLOW);
            default:
                motion_gated = 1'b0;
        endcase
    end

    assign motion_x = motion_gated ? 16'd0 : delta_x;
    assign motion_y = motion_gated ? 16'd0 : delta_y;

endmodule

>>> src/ofl_mode_ctrl.sv
// Lighting mode tracker with four saturating dwell counters.
// Depends on ofl_pkg for mode codes, thresholds and struct types.
module ofl_mode_ctrl
    import ofl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [3:0]  dwell_count,
    input  logic [12:0] shutter_value,
    input  logic [7:0]  raw_sum,
    output mode_info_t  info
);

    logic [1:0] mode_reg, mode_next;
    logic [3:0] l2b_cnt_reg, l2b_cnt_next;
    logic [3:0] s2l_cnt_reg, s2l_cnt_next;
    logic [3:0] b2l_cnt_reg, b2l_cnt_next;
    logic [3:0] l2s_cnt_reg, l2s_cnt_next;
    logic       l2b_cond, s2l_cond, b2l_cond, l2s_cond, fast_cond;

    // Switch conditions, all on the mode held before the item
    assign l2b_cond  = (mode_reg == MODE_LOW) && (shutter_value < SHUT_TO_BRIGHT);
    assign s2l_cond  = (mode_reg == MODE_SUPERLOW) && (shutter_value < SHUT_TO_LOW);
    assign b2l_cond  = (mode_reg == MODE_BRIGHT) && (shutter_value >= SHUT_TO_DARKER) &&
                       (raw_sum < RSUM_BRIGHT_TO_LOW);
    assign l2s_cond  = (mode_reg == MODE_LOW) && (shutter_value >= SHUT_TO_DARKER) &&
                       (raw_sum < RSUM_LOW_TO_SUPER);
    assign fast_cond = (mode_reg == MODE_SUPERLOW) && (shutter_value < SHUT_FAST_LOW);

    // Count while a condition holds, saturate, clear when it fails
    function automatic logic [3:0] cnt_step(input logic [3:0] cnt, input logic cond);
        logic [3:0] res;
        res = 4'd0;
        if (cond)
        begin
            res = (cnt < CNT_MAX) ? cnt + 4'd1 : cnt;
        end
        return res;
    endfunction

    // Resolve the next mode; later rules take priority
    always_comb
    begin
        l2b_cnt_next = cnt_step(l2b_cnt_reg, l2b_cond);
        s2l_cnt_next = cnt_step(s2l_cnt_reg, s2l_cond);
        b2l_cnt_next = cnt_step(b2l_cnt_reg, b2l_cond);
        l2s_cnt_next = cnt_step(l2s_cnt_reg, l2s_cond);
        mode_next    = mode_reg;
        if (l2b_cond && (l2b_cnt_next >= dwell_count))
        begin
            mode_next = MODE_BRIGHT;
        end
        if (s2l_cond && (s2l_cnt_next >= dwell_count))
        begin
            mode_next = MODE_LOW;
        end
        if (b2l_cond && (b2l_cnt_next >= dwell_count))
        begin
            mode_next = MODE_LOW;
        end
        if (l2s_cond && (l2s_cnt_next >= dwell_count))
        begin
            mode_next = MODE_SUPERLOW;
        end
        if (fast_cond)
        begin
            mode_next = MODE_LOW;
        end
    end

    assign info.cur_mode     = mode_reg;
    assign info.new_mode     = mode_next;
    assign info.mode_changed = (mode_next != mode_reg);

    // Commit state when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_BRIGHT;
            l2b_cnt_reg <= 4'd0;
            s2l_cnt_reg <= 4'd0;
            b2l_cnt_reg <= 4'd0;
            l2s_cnt_reg <= 4'd0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            l2b_cnt_reg <= l2b_cnt_next;
            s2l_cnt_reg <= s2l_cnt_next;
            b2l_cnt_reg <= b2l_cnt_next;
            l2s_cnt_reg <= l2s_cnt_next;
        end
    end

endmodule
